// ===== hw/rtl/sorted_array_priority_queue_core_defines.svh =====
// Assertion macros used by the queue core.
// Each check is sampled on the rising edge of clk and is off while rst is high.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication.
`define SAPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed");

// Next-cycle implication.
`define SAPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

// ===== hw/rtl/sapq_pkg.sv =====
package sapq_pkg;

  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned OCC_W    = 8;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/sorted_array_priority_queue_core.sv =====
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     action, prio, key, handle
// result    out        result_valid / result_ready status, out_prio, out_key,
//                                                  out_handle, occupancy
//
// For every item, the whole chain of cells inserts or removes in
// the same clock edge that accepts the transfer, and the result is registered.
// A new item is taken whenever the result register is empty or is drained in
// that cycle, so one item per clock is sustained while result_ready is high.
// Reset clears the fill count and the result valid flag; cell contents are
// left as they are and are only read once written.
// A stalled result holds the item side, since only one result is buffered.
module sorted_array_priority_queue_core
  import sapq_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                action,
  input  logic [PRIO_W-1:0]   prio,
  input  logic [KEY_W-1:0]    key,
  input  logic [HANDLE_W-1:0] handle,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [1:0]          status,
  output logic [PRIO_W-1:0]   out_prio,
  output logic [KEY_W-1:0]    out_key,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [OCC_W-1:0]    occupancy
);

`include "sorted_array_priority_queue_core_defines.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // The queue is stored as a chain of cells in ascending rank: cell 0 holds
  // the lowest-priority entry, which is the one a dequeue removes. An enqueue
  // shifts every entry that ranks ahead of the new one up by one cell and
  // drops the new entry into the gap; a dequeue shifts the whole chain down.
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          item_fire;
  logic          is_full;
  logic          is_empty;
  logic          enq_ok;
  logic          deq_ok;
  cell_cmd_t     cmd;

  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] cell_rank;
  entry_t           cell_entry [DEPTH];

  status_t             status_next;
  entry_t              out_next;
  logic [CW+OCC_W-1:0] occ_wide;

  assign item_ready = !result_valid || result_ready;
  assign item_fire  = item_valid && item_ready;
  assign is_full    = (count == CW'(DEPTH));
  assign is_empty   = (count == '0);
  assign enq_ok     = (action == ACT_ENQ) && !is_full;
  assign deq_ok     = (action == ACT_DEQ) && !is_empty;

  always_comb begin
    cmd.enq         = item_fire && enq_ok;
    cmd.deq         = item_fire && deq_ok;
    cmd.item.prio   = prio;
    cmd.item.key    = key;
    cmd.item.handle = handle;
  end

  // Thermometer view of the fill count: a cell is occupied below the count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CW'(i) < count);
    end
  end

  for (genvar c = 0; c < DEPTH; c++) begin : g_cell
    logic   lower_rank;
    entry_t lower_entry;
    entry_t upper_entry;

    if (c == 0) begin : g_bottom
      assign lower_rank  = 1'b0;
      assign lower_entry = '0;
    end else begin : g_mid_lo
      assign lower_rank  = cell_rank[c-1];
      assign lower_entry = cell_entry[c-1];
    end

    if (c == DEPTH - 1) begin : g_top
      assign upper_entry = '0;
    end else begin : g_mid_hi
      assign upper_entry = cell_entry[c+1];
    end

    sapq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occ[c]),
      .lower_rank  (lower_rank),
      .lower_entry (lower_entry),
      .upper_entry (upper_entry),
      .rank        (cell_rank[c]),
      .entry       (cell_entry[c])
    );
  end

  // Count and result for the item in hand.
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    out_next    = '0;
    if (action == ACT_ENQ) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        count_next = count - 1'b1;
        out_next   = cell_entry[0];
      end
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      status     <= status_next;
      out_prio   <= out_next.prio;
      out_key    <= out_next.key;
      out_handle <= out_next.handle;
      occupancy  <= occ_wide[OCC_W-1:0];
    end
  end

  // The fill count never passes the number of cells.
  `SAPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH))
  // An accepted enqueue with room grows the count by exactly one.
  `SAPQ_ASSERT_NEXT(a_enq_grows, item_fire && (action == ACT_ENQ) && !is_full,
                    count == $past(count) + 1'b1)
  // A dequeue on an empty queue reports it and leaves the queue empty.
  `SAPQ_ASSERT_NEXT(a_deq_empty, item_fire && (action == ACT_DEQ) && is_empty,
                    (status == ST_EMPTY) && (count == '0) && (out_prio == '0))
  // A dropped enqueue is only ever reported while the queue is full.
  `SAPQ_ASSERT_NOW(a_full_drop, result_valid && (status == ST_FULL),
                   count == CW'(DEPTH))

endmodule

// ===== hw/rtl/sapq_cell.sv =====
// One slot of the sorted chain. Cell 0 holds the lowest-ranked entry.
module sapq_cell
  import sapq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      lower_rank,
  input  entry_t    lower_entry,
  input  entry_t    upper_entry,
  output logic      rank,
  output entry_t    entry
);

  logic   ahead;
  entry_t entry_next;

  // The stored entry ranks ahead of the new one: higher priority, or equal
  // priority with a smaller key. Empty slots always count as ahead so that
  // the flag rises monotonically along the chain.
  always_comb begin
    ahead = (entry.prio > cmd.item.prio) ||
            ((entry.prio == cmd.item.prio) && (entry.key < cmd.item.key));
    rank  = ahead || !occupied;
  end

  always_comb begin
    entry_next = entry;
    if (cmd.enq) begin
      if (lower_rank) begin
        entry_next = lower_entry;
      end else if (rank) begin
        entry_next = cmd.item;
      end
    end else if (cmd.deq) begin
      entry_next = upper_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
